### rtl/core/lpsc_pkg.sv
package lpsc_pkg;

  // status codes carried on the final item of an access unit
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TRUNC    = 3'd1;
  localparam logic [2:0] ST_ZERO     = 3'd2;
  localparam logic [2:0] ST_OVERRUN  = 3'd3;
  localparam logic [2:0] ST_MISMATCH = 3'd4;

  // item kinds on the output channel
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // results caused by one input byte, in emission order:
  // start code, then a payload byte, then the unit status
  typedef struct packed {
    logic       start_code;
    logic       data;
    logic [7:0] data_byte;
    logic       stat;
    logic [2:0] status;
  } lpsc_grp_t;

  // start code 00 00 00 01, one byte per position
  function automatic logic [7:0] start_code_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd3:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### rtl/core/lpsc_parse.sv
module lpsc_parse
  import lpsc_pkg::*;
#(
  parameter int AU_SIZE_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_of_au_i,
  input  logic        last_of_au_i,
  input  logic [15:0] nal_count_i,
  input  logic [23:0] expected_size_i,
  output logic        grp_valid_o,
  output lpsc_grp_t   grp_o,
  input  logic        grp_space_i
);

  localparam int CW   = AU_SIZE_BITS + 1;
  localparam int ES_W = (AU_SIZE_BITS < 24) ? AU_SIZE_BITS : 24;

  localparam logic [1:0] PH_PREFIX  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_IDLE    = 2'd2;

  // input register
  logic        in_vld_q, in_vld_d;
  logic [7:0]  byte_q;
  logic        first_q, last_q;
  logic [15:0] ncnt_q;
  logic [23:0] esize_q;
  logic        adv;

  // parse state
  logic [1:0]      phase_q, phase_d;
  logic [1:0]      pbs_q, pbs_d;
  logic [23:0]     acc_q, acc_d;
  logic [31:0]     rem_q, rem_d;
  logic [15:0]     nd_q, nd_d;
  logic [CW-1:0]   cc_q, cc_d;
  logic [2:0]      err_q, err_d;
  logic [15:0]     lnc_q, lnc_d;
  logic [ES_W-1:0] les_q, les_d;

  logic [31:0] full_len;
  logic        active;
  lpsc_grp_t   grp;

  assign adv        = in_vld_q && grp_space_i;
  assign in_stall_o = in_vld_q && !grp_space_i;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_valid_i && !in_stall_o) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q  <= data_byte_i;
      first_q <= first_of_au_i;
      last_q  <= last_of_au_i;
      ncnt_q  <= nal_count_i;
      esize_q <= expected_size_i;
    end
  end

  // next parse state and results of the registered byte
  always_comb begin
    phase_d = phase_q;
    pbs_d   = pbs_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    nd_d    = nd_q;
    cc_d    = cc_q;
    err_d   = err_q;
    lnc_d   = lnc_q;
    les_d   = les_q;
    grp     = '0;

    // first byte of a unit restarts parsing
    if (first_q) begin
      phase_d = PH_PREFIX;
      pbs_d   = 2'd0;
      acc_d   = '0;
      rem_d   = '0;
      nd_d    = '0;
      cc_d    = '0;
      err_d   = ST_OK;
      lnc_d   = ncnt_q;
      les_d   = esize_q[ES_W-1:0];
    end

    // whole prefix once the fourth byte is in
    full_len = {acc_d, byte_q};

    active = (phase_d != PH_IDLE) && (err_d == ST_OK) && (nd_d < lnc_d);

    if (active) begin
      if (cc_d != '1) begin
        cc_d = cc_d + CW'(1);
      end
      if (phase_d == PH_PREFIX) begin
        if (pbs_d == 2'd3) begin
          pbs_d = 2'd0;
          if (full_len == 32'd0) begin
            err_d = ST_ZERO;
            acc_d = '0;
          end else begin
            grp.start_code = 1'b1;
            rem_d          = full_len;
            acc_d          = '0;
            phase_d        = PH_PAYLOAD;
          end
        end else begin
          pbs_d = pbs_d + 2'd1;
          acc_d = {acc_d[15:0], byte_q};
        end
      end else begin
        grp.data      = 1'b1;
        grp.data_byte = byte_q;
        rem_d         = rem_d - 32'd1;
        if (rem_d == 32'd0) begin
          nd_d    = nd_d + 16'd1;
          phase_d = PH_PREFIX;
          pbs_d   = 2'd0;
          acc_d   = '0;
        end
      end
    end

    // end of unit: settle the status
    if (last_q) begin
      if (phase_d != PH_IDLE && err_d == ST_OK) begin
        if (nd_d < lnc_d) begin
          err_d = (phase_d == PH_PAYLOAD) ? ST_OVERRUN : ST_TRUNC;
        end else if (cc_d != CW'(les_d)) begin
          err_d = ST_MISMATCH;
        end
      end
      phase_d     = PH_IDLE;
      grp.stat    = 1'b1;
      grp.status  = err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PREFIX;
      pbs_q   <= '0;
      acc_q   <= '0;
      rem_q   <= '0;
      nd_q    <= '0;
      cc_q    <= '0;
      err_q   <= ST_OK;
      lnc_q   <= '0;
      les_q   <= '0;
    end else if (adv) begin
      phase_q <= phase_d;
      pbs_q   <= pbs_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
      nd_q    <= nd_d;
      cc_q    <= cc_d;
      err_q   <= err_d;
      lnc_q   <= lnc_d;
      les_q   <= les_d;
    end
  end

  // only groups that carry at least one item go on
  assign grp_o       = grp;
  assign grp_valid_o = adv && (grp.start_code || grp.data || grp.stat);

endmodule

### rtl/core/lpsc_emit.sv
module lpsc_emit
  import lpsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       grp_valid_i,
  input  lpsc_grp_t  grp_i,
  output logic       grp_space_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       item_kind_o,
  output logic       is_last_o,
  output logic [2:0] status_o
);

  // two-entry group queue
  lpsc_grp_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  // group being emitted, one item per transaction
  lpsc_grp_t  cur_q, cur_d;
  logic [1:0] idx_q, idx_d;
  logic       take;

  assign grp_space_o = (cnt_q != 2'd2);
  assign take        = out_valid_o && !out_stall_i;

  // step through the current group, reload when it runs dry
  always_comb begin
    cur_d = cur_q;
    idx_d = idx_q;
    pop   = 1'b0;
    if (take) begin
      if (cur_q.start_code) begin
        if (idx_q == 2'd3) begin
          cur_d.start_code = 1'b0;
          idx_d            = 2'd0;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end else if (cur_q.data) begin
        cur_d.data = 1'b0;
      end else begin
        cur_d.stat = 1'b0;
      end
    end
    if (!cur_d.start_code && !cur_d.data && !cur_d.stat && cnt_q != 2'd0) begin
      cur_d = mem_q[rd_ptr_q];
      idx_d = 2'd0;
      pop   = 1'b1;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (grp_valid_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!grp_valid_i && pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
      idx_q    <= '0;
      cur_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
      cur_q <= cur_d;
      if (grp_valid_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  // queue storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (grp_valid_i) begin
      mem_q[wr_ptr_q] <= grp_i;
    end
  end

  // current item
  assign out_valid_o = cur_q.start_code || cur_q.data || cur_q.stat;

  always_comb begin
    out_byte_o  = 8'h00;
    item_kind_o = KIND_DATA;
    is_last_o   = 1'b0;
    status_o    = ST_OK;
    if (cur_q.start_code) begin
      out_byte_o = start_code_byte(idx_q);
    end else if (cur_q.data) begin
      out_byte_o = cur_q.data_byte;
    end else begin
      item_kind_o = KIND_STATUS;
      is_last_o   = 1'b1;
      status_o    = cur_q.status;
    end
  end

endmodule

### rtl/core/length_prefix_to_start_code.sv
// channel | direction | handshake            | payload
// input   | in        | in_valid_i/in_stall_o | data_byte, first_of_au, last_of_au,
//         |           |                      | nal_count, expected_size
// output  | out       | out_valid_o/out_stall_i | out_byte, item_kind, is_last, status
//
// one input byte is taken per cycle unless the input stalls; it is parsed from
// the input register, and its results pass through the group queue and the
// current-group register to the output port. a byte yields up to five output
// items (start code plus status), emitted one per cycle unless the output
// stalls, from a two-entry group queue; the input stalls while it is full.
// reset clears the parse state to zero NALs, expected size zero, no error.
// output stalls back up through the group queue to the input register.
module length_prefix_to_start_code
  import lpsc_pkg::*;
#(
  parameter int AU_SIZE_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_of_au_i,
  input  logic        last_of_au_i,
  input  logic [15:0] nal_count_i,
  input  logic [23:0] expected_size_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        item_kind_o,
  output logic        is_last_o,
  output logic [2:0]  status_o
);

  logic      grp_valid;
  lpsc_grp_t grp;
  logic      grp_space;

  // byte parser
  lpsc_parse #(
    .AU_SIZE_BITS(AU_SIZE_BITS)
  ) u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .first_of_au_i  (first_of_au_i),
    .last_of_au_i   (last_of_au_i),
    .nal_count_i    (nal_count_i),
    .expected_size_i(expected_size_i),
    .grp_valid_o    (grp_valid),
    .grp_o          (grp),
    .grp_space_i    (grp_space)
  );

  // result queue and item sequencer
  lpsc_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .grp_valid_i(grp_valid),
    .grp_i      (grp),
    .grp_space_o(grp_space),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .item_kind_o(item_kind_o),
    .is_last_o  (is_last_o),
    .status_o   (status_o)
  );

endmodule
